>>> rtl/scli_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and keyword tables for the serial command line interpreter.
// No dependencies; the other files in rtl/, apart from scli_ram, refer to this package by scoped names.

package scli_pkg;

  localparam int LINE_MAX_DEFAULT = 64;
  localparam int MAX_TOKENS       = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // What a poll carries, decided in the front end
  typedef enum logic [1:0] {
    CK_NONE,
    CK_CR,
    CK_LF,
    CK_OTHER
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [7:0] ch;
  } poll_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_RECV,
    MODE_PROC,
    MODE_EXEC,
    MODE_ERR
  } mode_t;

  typedef enum logic [3:0] {
    RSP_NONE,
    RSP_HELP,
    RSP_ON,
    RSP_OFF,
    RSP_TOGGLE,
    RSP_STATUS,
    RSP_MISSING,
    RSP_INVALID,
    RSP_UNKNOWN,
    RSP_ERROR
  } resp_t;

  // Keywords: the first three are commands, the last three are LED arguments
  typedef enum logic [2:0] {
    KW_HELP,
    KW_LED,
    KW_STATUS,
    KW_ON,
    KW_OFF,
    KW_TOGGLE
  } kw_t;

  localparam int NUM_KW = 6;
  localparam int POS_W  = 3;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] kw_len(input kw_t kw);
    logic [POS_W-1:0] n;
    unique case (kw)
      KW_HELP:   n = 3'd4;
      KW_LED:    n = 3'd3;
      KW_STATUS: n = 3'd6;
      KW_ON:     n = 3'd2;
      KW_OFF:    n = 3'd3;
      KW_TOGGLE: n = 3'd6;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // Character p of a keyword; words are left-justified, first character on top
  function automatic logic [7:0] kw_char(input kw_t kw, input logic [POS_W-1:0] p);
    logic [47:0] word;
    logic [47:0] shifted;
    unique case (kw)
      KW_HELP:   word = {"help", 16'h0000};
      KW_LED:    word = {"led", 24'h000000};
      KW_STATUS: word = "status";
      KW_ON:     word = {"on", 32'h00000000};
      KW_OFF:    word = {"off", 24'h000000};
      KW_TOGGLE: word = "toggle";
      default:   word = '0;
    endcase
    shifted = word << {p, 3'b000};
    return shifted[47:40];
  endfunction

  // Decide the command from the token count (saturated at two) and keyword hits
  function automatic resp_t classify(input logic [1:0] cnt, input logic [NUM_KW-1:0] hit);
    resp_t r;
    if (cnt == 2'd0) begin
      r = RSP_NONE;
    end else if (hit[KW_HELP]) begin
      r = RSP_HELP;
    end else if (hit[KW_LED]) begin
      if (cnt == 2'd1) begin
        r = RSP_MISSING;
      end else if (hit[KW_ON]) begin
        r = RSP_ON;
      end else if (hit[KW_OFF]) begin
        r = RSP_OFF;
      end else if (hit[KW_TOGGLE]) begin
        r = RSP_TOGGLE;
      end else begin
        r = RSP_INVALID;
      end
    end else if (hit[KW_STATUS]) begin
      r = RSP_STATUS;
    end else begin
      r = RSP_UNKNOWN;
    end
    return r;
  endfunction

endpackage

>>> rtl/scli_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.

module scli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/scli_front.sv
`timescale 1ns / 1ps
// Front end: accepts polls from the input stream, classifies the byte and
// registers the result for the command queue. Depends on scli_pkg.

module scli_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] rx_char
  input  logic            s_axis_tuser,   // [0] char_valid
  input  logic            q_ready,
  output logic            f_valid,
  output scli_pkg::poll_t f_poll
);

  scli_pkg::poll_t poll_next;
  logic            accept;

  assign s_axis_tready = !f_valid || q_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    poll_next.ch = s_axis_tdata;
    if (!s_axis_tuser) begin
      poll_next.kind = scli_pkg::CK_NONE;
    end else if (s_axis_tdata == scli_pkg::CH_CR) begin
      poll_next.kind = scli_pkg::CK_CR;
    end else if (s_axis_tdata == scli_pkg::CH_LF) begin
      poll_next.kind = scli_pkg::CK_LF;
    end else begin
      poll_next.kind = scli_pkg::CK_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_poll <= poll_next;
    end
  end

endmodule

>>> rtl/scli_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified polls between the front end and the back end.
// Depends on scli_pkg.

module scli_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  scli_pkg::poll_t in_poll,
  output logic            out_valid,
  input  logic            out_pop,
  output scli_pkg::poll_t out_poll
);

  localparam int DEPTH = scli_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  scli_pkg::poll_t slot [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign out_poll  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (out_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, out_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_poll;
    end
  end

endmodule

>>> rtl/scli_back.sv
`timescale 1ns / 1ps
// Back end: mode machine, line store, token scanner and result register.
// Depends on scli_pkg and scli_ram.

module scli_back #(
  parameter int LINE_MAX = scli_pkg::LINE_MAX_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  scli_pkg::poll_t q_poll,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [3:0] response, [4] led_level, [7:5] zero
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int NK = scli_pkg::NUM_KW;
  localparam int PW = scli_pkg::POS_W;

  scli_pkg::mode_t mode, mode_next;
  logic [AW-1:0]   fill_idx, fill_next;
  logic            led_on, led_next;
  scli_pkg::resp_t parsed, parsed_next;

  logic            out_vld, out_vld_next;
  scli_pkg::resp_t out_resp, out_resp_next;
  logic            out_led, out_led_next;
  logic            out_free;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      rd_data;

  // scanner state
  logic [AW-1:0]   scan_idx, scan_next;
  logic            rd_vld, rd_vld_next;
  logic            scan_done, done_next;
  logic            stopped, stop_next;
  logic            in_tok, in_tok_next;
  logic [1:0]      tok_cnt, tok_cnt_next;
  logic [PW-1:0]   pos, pos_next;
  logic [NK-1:0]   flag, flag_next;
  logic [NK-1:0]   hit, hit_next;
  logic            start_scan;
  logic            close_tok;

  logic [NK-1:0]   cur_flag, step_flag, close_hit;
  logic [PW-1:0]   cur_pos, step_pos;
  logic [7:0]      folded;

  scli_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_poll.ch),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  assign out_free      = !out_vld || m_axis_tready;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {3'b000, out_led, out_resp};

  // Keyword match for one token byte, and keyword hits when a token closes
  always_comb begin
    cur_flag = in_tok ? flag : '1;
    cur_pos  = in_tok ? pos : '0;
    folded   = scli_pkg::fold_case(rd_data);
    for (int k = 0; k < NK; k++) begin
      step_flag[k] = cur_flag[k]
                     && (cur_pos < scli_pkg::kw_len(scli_pkg::kw_t'(k)))
                     && (folded == scli_pkg::kw_char(scli_pkg::kw_t'(k), cur_pos));
      close_hit[k] = flag[k] && (pos == scli_pkg::kw_len(scli_pkg::kw_t'(k)));
    end
    step_pos = (cur_pos == '1) ? cur_pos : cur_pos + 1'b1;
  end

  // Line scan: one read per cycle, each byte consumed in the cycle after its read
  always_comb begin
    scan_next    = scan_idx;
    rd_vld_next  = 1'b0;
    done_next    = scan_done;
    stop_next    = stopped;
    in_tok_next  = in_tok;
    tok_cnt_next = tok_cnt;
    pos_next     = pos;
    flag_next    = flag;
    hit_next     = hit;
    close_tok    = 1'b0;
    if (start_scan) begin
      scan_next    = '0;
      done_next    = 1'b0;
      stop_next    = 1'b0;
      in_tok_next  = 1'b0;
      tok_cnt_next = 2'd0;
      hit_next     = '0;
    end else if (mode == scli_pkg::MODE_PROC && !scan_done) begin
      if (!stopped && scan_idx != fill_idx) begin
        scan_next   = scan_idx + 1'b1;
        rd_vld_next = 1'b1;
      end
      if (rd_vld && !stopped) begin
        if (rd_data == scli_pkg::CH_SPACE || rd_data == scli_pkg::CH_NUL) begin
          close_tok = in_tok;
          // a zero byte ends the text
          if (rd_data == scli_pkg::CH_NUL) begin
            stop_next = 1'b1;
          end
        end else begin
          in_tok_next = 1'b1;
          flag_next   = step_flag;
          pos_next    = step_pos;
        end
      end else if (!rd_vld && (stopped || scan_idx == fill_idx)) begin
        close_tok = in_tok;
        done_next = 1'b1;
      end
      if (close_tok) begin
        in_tok_next = 1'b0;
        if (tok_cnt == 2'd0) begin
          hit_next[scli_pkg::KW_HELP]   = close_hit[scli_pkg::KW_HELP];
          hit_next[scli_pkg::KW_LED]    = close_hit[scli_pkg::KW_LED];
          hit_next[scli_pkg::KW_STATUS] = close_hit[scli_pkg::KW_STATUS];
          tok_cnt_next = 2'd1;
          if (scli_pkg::MAX_TOKENS == 1) begin
            stop_next = 1'b1;
          end
        end else begin
          // the second token sets the argument hits and stops the scan; later tokens never change the outcome
          hit_next[scli_pkg::KW_ON]     = close_hit[scli_pkg::KW_ON];
          hit_next[scli_pkg::KW_OFF]    = close_hit[scli_pkg::KW_OFF];
          hit_next[scli_pkg::KW_TOGGLE] = close_hit[scli_pkg::KW_TOGGLE];
          tok_cnt_next = 2'd2;
          stop_next    = 1'b1;
        end
      end
    end
  end

  // Mode machine: every popped poll makes exactly one result beat
  always_comb begin
    mode_next     = mode;
    fill_next     = fill_idx;
    led_next      = led_on;
    parsed_next   = parsed;
    start_scan    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = fill_idx;
    out_vld_next  = out_vld && !m_axis_tready;
    out_resp_next = out_resp;
    out_led_next  = out_led;
    q_pop = q_valid && out_free && (mode != scli_pkg::MODE_PROC || scan_done);
    if (q_pop) begin
      out_vld_next  = 1'b1;
      out_resp_next = scli_pkg::RSP_NONE;
      unique case (mode)
        scli_pkg::MODE_RECV: begin
          if (q_poll.kind == scli_pkg::CK_CR) begin
            mode_next  = scli_pkg::MODE_PROC;
            start_scan = 1'b1;
          end else if (q_poll.kind != scli_pkg::CK_NONE) begin
            if (fill_idx < AW'(LINE_MAX - 1)) begin
              ram_we    = 1'b1;
              fill_next = fill_idx + 1'b1;
            end else begin
              mode_next = scli_pkg::MODE_ERR;
            end
          end
        end
        scli_pkg::MODE_PROC: begin
          parsed_next = scli_pkg::classify(tok_cnt, hit);
          mode_next   = scli_pkg::MODE_EXEC;
        end
        scli_pkg::MODE_EXEC: begin
          out_resp_next = parsed;
          unique case (parsed)
            scli_pkg::RSP_ON:     led_next = 1'b1;
            scli_pkg::RSP_OFF:    led_next = 1'b0;
            scli_pkg::RSP_TOGGLE: led_next = !led_on;
            default:              led_next = led_on;
          endcase
          fill_next = '0;
          mode_next = scli_pkg::MODE_IDLE;
        end
        scli_pkg::MODE_ERR: begin
          out_resp_next = scli_pkg::RSP_ERROR;
          fill_next     = '0;
          mode_next     = scli_pkg::MODE_IDLE;
        end
        default: begin
          // idle, and unused codes fall back to idle
          mode_next = scli_pkg::MODE_IDLE;
          if (q_poll.kind == scli_pkg::CK_OTHER) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            fill_next = AW'(1);
            mode_next = scli_pkg::MODE_RECV;
          end
        end
      endcase
      out_led_next = led_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= scli_pkg::MODE_IDLE;
      fill_idx  <= '0;
      led_on    <= 1'b0;
      parsed    <= scli_pkg::RSP_NONE;
      out_vld   <= 1'b0;
      rd_vld    <= 1'b0;
      scan_done <= 1'b0;
      stopped   <= 1'b0;
      in_tok    <= 1'b0;
      tok_cnt   <= 2'd0;
    end else begin
      mode      <= mode_next;
      fill_idx  <= fill_next;
      led_on    <= led_next;
      parsed    <= parsed_next;
      out_vld   <= out_vld_next;
      rd_vld    <= rd_vld_next;
      scan_done <= done_next;
      stopped   <= stop_next;
      in_tok    <= in_tok_next;
      tok_cnt   <= tok_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_next;
    pos      <= pos_next;
    flag     <= flag_next;
    hit      <= hit_next;
    out_resp <= out_resp_next;
    out_led  <= out_led_next;
  end

  a_led_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && mode == scli_pkg::MODE_EXEC) |=> $stable(led_on))
    else $error("LED level changed outside command execution");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (q_pop && mode == scli_pkg::MODE_ERR) |=>
      (out_vld && out_resp == scli_pkg::RSP_ERROR && mode == scli_pkg::MODE_IDLE))
    else $error("overflowed line did not report error and return to idle");

  a_scan_in_line: assert property (@(posedge clk) disable iff (rst)
    (mode == scli_pkg::MODE_PROC) |-> (scan_idx <= fill_idx))
    else $error("line scan ran past the stored bytes");

  a_exec_clears_line: assert property (@(posedge clk) disable iff (rst)
    (q_pop && mode == scli_pkg::MODE_EXEC) |=>
      (fill_idx == '0 && mode == scli_pkg::MODE_IDLE))
    else $error("line not cleared after execution");

endmodule

>>> rtl/serial_command_line_interpreter.sv
`timescale 1ns / 1ps
// Serial command line interpreter: usage notes
//
// Input stream (s_axis_*): one beat per poll. s_axis_tuser flags a received
// byte, s_axis_tdata holds it. Output stream (m_axis_*): exactly one beat per
// poll, in order, with the response code and the LED level after that poll.
// Lines end with CR; leading CR/LF in idle are skipped. Commands: help,
// led on|off|toggle, status, matched without regard to case.
// A poll passes the front register and the command queue before its result is registered.
// Throughput: one poll per cycle while m_axis_tready is high, except the poll
// right after a CR, which waits for the line scan: one line-store read per
// cycle, until the scan of the stored line is done.
// Reset (rst, synchronous): mode idle, LED off, line and queue empty; no
// clearing pass is needed.
// A stalled m_axis_tready holds the result register; the two-entry command
// queue and the front register then fill and s_axis_tready drops.
// Depends on scli_pkg, scli_front, scli_queue, scli_back, scli_ram.

module serial_command_line_interpreter #(
  parameter int LINE_MAX = scli_pkg::LINE_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] rx_char
  input  logic       s_axis_tuser,    // [0] char_valid
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata     // [3:0] response, [4] led_level, [7:5] zero
);

  logic            f_valid;
  scli_pkg::poll_t f_poll;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;
  scli_pkg::poll_t q_poll;

  scli_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready       (q_ready),
    .f_valid       (f_valid),
    .f_poll        (f_poll)
  );

  scli_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (q_ready),
    .in_poll   (f_poll),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_poll  (q_poll)
  );

  scli_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_poll        (q_poll),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for serial_command_line_interpreter: a stimulus table, then random command lines,
// checked beat by beat against an in-bench model of the line interpreter.
// Depends on scli_pkg and the RTL under rtl/.

module tb_top;

  localparam int LINE_LEN       = scli_pkg::LINE_MAX_DEFAULT;
  localparam int RANDOM_BYTES   = 1650;
  localparam int NUM_PHASES     = 5;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int NUM_ROWS       = 22;
  localparam int NEAR_MISS_N    = 17;

  typedef struct {
    scli_pkg::resp_t resp;
    logic            led;
  } reply_t;

  typedef struct {
    logic            valid;
    logic [7:0]      ch;
    bit              typed;
    scli_pkg::resp_t resp;
    logic            led;
  } poll_row_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] rx_char
  logic       s_axis_tuser;   // [0] char_valid
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [3:0] response, [4] led_level, [7:5] zero

  // Interpreter state as the testbench sees it
  scli_pkg::mode_t cli_mode;
  logic [7:0]      line_buf [LINE_LEN];
  int unsigned     line_fill;
  logic            led_state;
  scli_pkg::resp_t pending_cmd;

  reply_t      replies_due [$];
  logic [7:0]  line_bytes [$];
  int          mismatches;
  int          bytes_sent;
  int          idle_cycles;
  int          hold_left;
  int          send_idle_pct;
  int          recv_stall_pct;

  int send_idle_by_phase  [NUM_PHASES] = '{0, 70, 0, 11, 0};
  int recv_stall_by_phase [NUM_PHASES] = '{0, 0, 70, 11, 0};

  string near_miss [NEAR_MISS_N] = '{"hel", "helpp", "le", "ledon", "o", "of", "offf",
                                     "toggl", "togglee", "statu", "statuss", "on", "off",
                                     "toggle", "led", "help", "status"};

  poll_row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, 8'h00,              1'b1, scli_pkg::RSP_NONE,    1'b0},  // empty poll after reset
    '{1'b1, scli_pkg::CH_LF,    1'b1, scli_pkg::RSP_NONE,    1'b0},  // leading LF skipped
    '{1'b1, scli_pkg::CH_CR,    1'b1, scli_pkg::RSP_NONE,    1'b0},  // leading CR skipped
    '{1'b1, "L",                1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, "E",                1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, "D",                1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, scli_pkg::CH_SPACE, 1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, "O",                1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, "N",                1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, scli_pkg::CH_CR,    1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, "x",                1'b0, scli_pkg::RSP_NONE,    1'b0},  // dropped during scan
    '{1'b0, 8'h00,              1'b1, scli_pkg::RSP_ON,      1'b1},
    '{1'b1, 8'hFF,              1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, scli_pkg::CH_NUL,   1'b0, scli_pkg::RSP_NONE,    1'b0},  // zero byte ends text
    '{1'b1, "s",                1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, scli_pkg::CH_CR,    1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b0, 8'hFF,              1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, scli_pkg::CH_CR,    1'b1, scli_pkg::RSP_UNKNOWN, 1'b1},  // CR dropped in execute
    '{1'b1, scli_pkg::CH_SPACE, 1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b1, scli_pkg::CH_CR,    1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b0, 8'h00,              1'b0, scli_pkg::RSP_NONE,    1'b0},
    '{1'b0, 8'h00,              1'b1, scli_pkg::RSP_NONE,    1'b1}   // all-space line, LED kept
  };

  serial_command_line_interpreter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- line interpreter model

  function automatic bit word_matches(int unsigned start, int unsigned len, string word);
    logic [7:0] c;
    if (len != word.len()) return 1'b0;
    for (int unsigned k = 0; k < len; k++) begin
      c = line_buf[start + k];
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      if (c != word[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic scli_pkg::resp_t decode_line();
    int unsigned ntok;
    int unsigned i;
    int unsigned s;
    int unsigned tok_start [2];
    int unsigned tok_len [2];
    ntok = 0;
    i = 0;
    tok_start = '{0, 0};
    tok_len = '{0, 0};
    // Split on runs of spaces; stop at a zero byte or once the token limit is reached
    while (i < line_fill && line_buf[i] != scli_pkg::CH_NUL
           && ntok < scli_pkg::MAX_TOKENS) begin
      if (line_buf[i] == scli_pkg::CH_SPACE) begin
        i++;
      end else begin
        s = i;
        while (i < line_fill && line_buf[i] != scli_pkg::CH_NUL
               && line_buf[i] != scli_pkg::CH_SPACE) i++;
        if (ntok < 2) begin
          tok_start[ntok] = s;
          tok_len[ntok] = i - s;
        end
        ntok++;
      end
    end
    if (ntok == 0) return scli_pkg::RSP_NONE;
    if (word_matches(tok_start[0], tok_len[0], "help")) return scli_pkg::RSP_HELP;
    if (word_matches(tok_start[0], tok_len[0], "led")) begin
      if (ntok < 2) return scli_pkg::RSP_MISSING;
      if (word_matches(tok_start[1], tok_len[1], "on")) return scli_pkg::RSP_ON;
      if (word_matches(tok_start[1], tok_len[1], "off")) return scli_pkg::RSP_OFF;
      if (word_matches(tok_start[1], tok_len[1], "toggle")) return scli_pkg::RSP_TOGGLE;
      return scli_pkg::RSP_INVALID;
    end
    if (word_matches(tok_start[0], tok_len[0], "status")) return scli_pkg::RSP_STATUS;
    return scli_pkg::RSP_UNKNOWN;
  endfunction

  function automatic void interpret_poll(input logic v, input logic [7:0] c,
                                         output scli_pkg::resp_t r, output logic led);
    r = scli_pkg::RSP_NONE;
    case (cli_mode)
      scli_pkg::MODE_RECV: begin
        if (v) begin
          if (c == scli_pkg::CH_CR) begin
            cli_mode = scli_pkg::MODE_PROC;
          end else if (line_fill < LINE_LEN - 1) begin
            line_buf[line_fill] = c;
            line_fill++;
          end else begin
            cli_mode = scli_pkg::MODE_ERR;
          end
        end
      end
      scli_pkg::MODE_PROC: begin
        pending_cmd = decode_line();
        cli_mode = scli_pkg::MODE_EXEC;
      end
      scli_pkg::MODE_EXEC: begin
        r = pending_cmd;
        case (r)
          scli_pkg::RSP_ON:     led_state = 1'b1;
          scli_pkg::RSP_OFF:    led_state = 1'b0;
          scli_pkg::RSP_TOGGLE: led_state = ~led_state;
          default: ;
        endcase
        line_fill = 0;
        cli_mode = scli_pkg::MODE_IDLE;
      end
      scli_pkg::MODE_ERR: begin
        r = scli_pkg::RSP_ERROR;
        line_fill = 0;
        cli_mode = scli_pkg::MODE_IDLE;
      end
      default: begin
        cli_mode = scli_pkg::MODE_IDLE;
        if (v && c != scli_pkg::CH_CR && c != scli_pkg::CH_LF) begin
          line_buf[0] = c;
          line_fill = 1;
          cli_mode = scli_pkg::MODE_RECV;
        end
      end
    endcase
    led = led_state;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_poll(input logic v, input logic [7:0] c, input bit typed,
                           input scli_pkg::resp_t t_resp, input logic t_led);
    reply_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 1'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= v;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    interpret_poll(v, c, r.resp, r.led);
    if (typed) begin
      r.resp = t_resp;
      r.led  = t_led;
    end
    replies_due.push_back(r);
    if (v) bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_poll(input logic v);
    send_poll(v, 8'($urandom), 1'b0, scli_pkg::RSP_NONE, 1'b0);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    wait (replies_due.size() == 0);
    @(negedge clk);
  endtask

  function automatic void add_word(string w);
    logic [7:0] c;
    for (int k = 0; k < w.len(); k++) begin
      c = w[k];
      if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
      line_bytes.push_back(c);
    end
  endfunction

  function automatic void add_spaces(int lo, int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) line_bytes.push_back(scli_pkg::CH_SPACE);
  endfunction

  function automatic void add_random_token();
    int n;
    n = $urandom_range(6, 1);
    repeat (n) line_bytes.push_back(8'($urandom_range("z", "a")));
  endfunction

  function automatic void add_odd_word();
    if ($urandom_range(1)) add_word(near_miss[$urandom_range(NEAR_MISS_N - 1)]);
    else add_random_token();
  endfunction

  function automatic void build_line();
    int kind;
    int n;
    line_bytes.delete();
    kind = $urandom_range(19);
    // Weight kinds 0 to 7 twice: the well-formed commands and the first near misses
    if (kind > 11) kind = kind - 12;
    add_spaces(0, 2);
    case (kind)
      0: add_word("help");
      1: begin add_word("led"); add_spaces(1, 3); add_word("on"); end
      2: begin add_word("led"); add_spaces(1, 3); add_word("off"); end
      3: begin add_word("led"); add_spaces(1, 3); add_word("toggle"); end
      4: add_word("status");
      5: add_word("led");
      6: begin add_word("led"); add_spaces(1, 3); add_odd_word(); end
      7: add_odd_word();
      8: add_random_token();
      9: begin
        n = $urandom_range(12, 3);
        repeat (n) begin
          add_odd_word();
          add_spaces(1, 2);
        end
      end
      10: begin
        n = $urandom_range(20, 1);
        repeat (n) line_bytes.push_back(8'($urandom));
      end
      default: begin
        // Long line around the store limit
        n = $urandom_range(70, 60);
        repeat (n) line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
      end
    endcase
    if (kind <= 6 && $urandom_range(3) == 0) begin
      add_spaces(1, 2);
      add_odd_word();
    end
    add_spaces(0, 2);
    if ($urandom_range(15) == 0) begin
      line_bytes.insert($urandom_range(line_bytes.size() - 1),
                        $urandom_range(1) ? scli_pkg::CH_NUL : scli_pkg::CH_LF);
    end
  endfunction

  task automatic send_line();
    int n;
    n = $urandom_range(2);
    // Noise before the line: empty polls and stray line ends
    repeat (n) begin
      case ($urandom_range(2))
        0: send_random_poll(1'b0);
        1: send_poll(1'b1, scli_pkg::CH_CR, 1'b0, scli_pkg::RSP_NONE, 1'b0);
        default: send_poll(1'b1, scli_pkg::CH_LF, 1'b0, scli_pkg::RSP_NONE, 1'b0);
      endcase
    end
    build_line();
    foreach (line_bytes[k]) send_poll(1'b1, line_bytes[k], 1'b0, scli_pkg::RSP_NONE, 1'b0);
    send_poll(1'b1, scli_pkg::CH_CR, 1'b0, scli_pkg::RSP_NONE, 1'b0);
    // Mostly let process and execute pass; sometimes cut in early
    n = ($urandom_range(7) == 0) ? $urandom_range(1) : 2;
    repeat (n) send_random_poll(1'($urandom));
  endtask

  // ---------------------------------------------------------------- sink and checks

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("result beat with no poll waiting: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        due = replies_due.pop_front();
        if (m_axis_tdata[3:0] !== due.resp) begin
          $error("response: expected %0d, got %0d", due.resp, m_axis_tdata[3:0]);
          mismatches++;
        end
        if (m_axis_tdata[4] !== due.led) begin
          $error("led_level: expected %0d, got %0d", due.led, m_axis_tdata[4]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int phase;
    int next_phase;
    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tuser   = 1'b0;
    mismatches     = 0;
    bytes_sent     = 0;
    idle_cycles    = 0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cli_mode       = scli_pkg::MODE_IDLE;
    line_fill      = 0;
    led_state      = 1'b0;
    pending_cmd    = scli_pkg::RSP_NONE;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      send_poll(directed_rows[k].valid, directed_rows[k].ch, directed_rows[k].typed,
                directed_rows[k].resp, directed_rows[k].led);
    end

    bytes_sent = 0;
    phase = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      next_phase = bytes_sent * NUM_PHASES / RANDOM_BYTES;
      if (next_phase != phase) begin
        phase = next_phase;
        pause_until_drained();
        send_idle_pct  = send_idle_by_phase[phase];
        recv_stall_pct = recv_stall_by_phase[phase];
        // Long sink hold-off while polls keep coming: fill the queue, stall the input
        if (phase == NUM_PHASES - 1) hold_left = HOLD_CYCLES;
      end
      send_line();
    end

    s_axis_tvalid <= 1'b0;
    wait (replies_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
